// File: src/ascd_pkg.sv
`default_nettype none
package ascd_pkg;

  localparam int NumRanges = 6;
  localparam int ValW      = 14;
  localparam int DvdW      = 23;
  localparam int NumCells  = DvdW;

  typedef logic [ValW-1:0] val_t;

  // scheme index into the alphabet table
  typedef enum logic [4:0] {
    SchDigits = 5'd0,  SchLower  = 5'd1,  SchLowDot  = 5'd2,  SchLatin  = 5'd3,
    SchLatNum = 5'd4,  SchLatDot = 5'd5,  SchLatNDot = 5'd6,  SchLatAll = 5'd7,
    SchPrint  = 5'd8,  SchPrintS = 5'd9,  SchCyrLow  = 5'd10, SchCyrDot = 5'd11,
    SchCyr    = 5'd12, SchCyrAll = 5'd13, SchMixA    = 5'd14, SchMixB   = 5'd15,
    SchByte   = 5'd16, SchBmp12  = 5'd17, SchWide    = 5'd18
  } scheme_e;

  localparam logic [15:0] IdByte  = 16'hff00;
  localparam logic [15:0] IdBmp12 = 16'hff01;

  typedef struct packed {
    logic [2:0]                cnt;
    logic [NumRanges-1:0][ValW-1:0] lo;
    logic [NumRanges-1:0][ValW-1:0] hi;
    val_t                      len;
    val_t                      p23;  // 2^23 mod len
  } alpha_t;

  // one link of the remainder chain
  typedef struct packed {
    logic            valid;
    logic            req;
    logic            hit;
    logic            neg;
    scheme_e         sch;
    val_t            m;
    val_t            rem;
    logic [DvdW-1:0] dvd;
  } cell_t;

  function automatic scheme_e scheme_idx_f(logic [15:0] id);
    scheme_e s;
    if (id[15:4] == 12'd0) s = scheme_e'({1'b0, id[3:0]});
    else if (id == IdByte) s = SchByte;
    else if (id == IdBmp12) s = SchBmp12;
    else s = SchWide;
    return s;
  endfunction

  function automatic val_t range_len_f(alpha_t a, int i);
    return val_t'(a.hi[i] - a.lo[i] + val_t'(1));
  endfunction

  function automatic alpha_t alpha_f(scheme_e s);
    alpha_t a;
    a = '0;
    unique case (s)
      SchDigits: begin
        a.cnt = 3'd1; a.lo[0] = 14'h30; a.hi[0] = 14'h39; a.p23 = 14'd8;
      end
      SchLower: begin
        a.cnt = 3'd1; a.lo[0] = 14'h61; a.hi[0] = 14'h7a; a.p23 = 14'd20;
      end
      SchLowDot: begin
        a.cnt = 3'd2; a.lo[0] = 14'h61; a.hi[0] = 14'h7a;
        a.lo[1] = 14'h2e; a.hi[1] = 14'h2e; a.p23 = 14'd5;
      end
      SchLatin: begin
        a.cnt = 3'd2; a.lo[0] = 14'h61; a.hi[0] = 14'h7a;
        a.lo[1] = 14'h41; a.hi[1] = 14'h5a; a.p23 = 14'd20;
      end
      SchLatNum: begin
        a.cnt = 3'd3; a.lo[0] = 14'h61; a.hi[0] = 14'h7a;
        a.lo[1] = 14'h41; a.hi[1] = 14'h5a;
        a.lo[2] = 14'h30; a.hi[2] = 14'h39; a.p23 = 14'd8;
      end
      SchLatDot: begin
        a.cnt = 3'd3; a.lo[0] = 14'h61; a.hi[0] = 14'h7a;
        a.lo[1] = 14'h41; a.hi[1] = 14'h5a;
        a.lo[2] = 14'h2e; a.hi[2] = 14'h2e; a.p23 = 14'd33;
      end
      SchLatNDot: begin
        a.cnt = 3'd4; a.lo[0] = 14'h61; a.hi[0] = 14'h7a;
        a.lo[1] = 14'h41; a.hi[1] = 14'h5a;
        a.lo[2] = 14'h30; a.hi[2] = 14'h39;
        a.lo[3] = 14'h2e; a.hi[3] = 14'h2e; a.p23 = 14'd32;
      end
      SchLatAll: begin
        a.cnt = 3'd6; a.lo[0] = 14'h61; a.hi[0] = 14'h7a;
        a.lo[1] = 14'h41; a.hi[1] = 14'h5a;
        a.lo[2] = 14'h30; a.hi[2] = 14'h39;
        a.lo[3] = 14'h2e; a.hi[3] = 14'h2e;
        a.lo[4] = 14'h21; a.hi[4] = 14'h21;
        a.lo[5] = 14'h20; a.hi[5] = 14'h20; a.p23 = 14'd33;
      end
      SchPrint: begin
        a.cnt = 3'd1; a.lo[0] = 14'h21; a.hi[0] = 14'h7e; a.p23 = 14'd48;
      end
      SchPrintS: begin
        a.cnt = 3'd1; a.lo[0] = 14'h20; a.hi[0] = 14'h7e; a.p23 = 14'd13;
      end
      SchCyrLow: begin
        a.cnt = 3'd1; a.lo[0] = 14'h430; a.hi[0] = 14'h44f; a.p23 = 14'd0;
      end
      SchCyrDot: begin
        a.cnt = 3'd2; a.lo[0] = 14'h430; a.hi[0] = 14'h44f;
        a.lo[1] = 14'h2e; a.hi[1] = 14'h2e; a.p23 = 14'd8;
      end
      SchCyr: begin
        a.cnt = 3'd2; a.lo[0] = 14'h430; a.hi[0] = 14'h44f;
        a.lo[1] = 14'h410; a.hi[1] = 14'h42f; a.p23 = 14'd0;
      end
      SchCyrAll: begin
        a.cnt = 3'd5; a.lo[0] = 14'h430; a.hi[0] = 14'h44f;
        a.lo[1] = 14'h410; a.hi[1] = 14'h42f;
        a.lo[2] = 14'h2e; a.hi[2] = 14'h2e;
        a.lo[3] = 14'h21; a.hi[3] = 14'h21;
        a.lo[4] = 14'h20; a.hi[4] = 14'h20; a.p23 = 14'd7;
      end
      SchMixA, SchMixB: begin
        a.cnt = 3'd3; a.lo[0] = 14'h20; a.hi[0] = 14'h7e;
        a.lo[1] = 14'h430; a.hi[1] = 14'h44f;
        a.lo[2] = 14'h410; a.hi[2] = 14'h42f; a.p23 = 14'd86;
      end
      SchByte: begin
        a.cnt = 3'd1; a.lo[0] = 14'h20; a.hi[0] = 14'hff; a.p23 = 14'd32;
      end
      SchBmp12: begin
        a.cnt = 3'd1; a.lo[0] = 14'h20; a.hi[0] = 14'hfff; a.p23 = 14'd512;
      end
      default: begin
        a.cnt = 3'd1; a.lo[0] = 14'h20; a.hi[0] = 14'h32ff; a.p23 = 14'd1152;
      end
    endcase
    a.len = '0;
    for (int i = 0; i < NumRanges; i++) begin
      if (3'(i) < a.cnt) a.len = val_t'(a.len + range_len_f(a, i));
    end
    return a;
  endfunction

endpackage
`default_nettype wire

// File: src/ascd_front.sv
`default_nettype none
module ascd_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic                  req_type_i,
  input  wire logic [15:0]           scheme_type_i,
  input  wire logic [20:0]           symbol_or_index_i,
  input  wire logic signed [15:0]    shift_i,
  output ascd_pkg::cell_t            cell_o
);

  ascd_pkg::scheme_e sch;
  ascd_pkg::alpha_t  a;
  ascd_pkg::val_t    base, pos;
  logic              hit;
  logic [20:0]       a0;
  logic [ascd_pkg::DvdW-1:0] v;
  ascd_pkg::cell_t   cell_d, cell_q;

  always_comb begin
    sch  = ascd_pkg::scheme_idx_f(scheme_type_i);
    a    = ascd_pkg::alpha_f(sch);
    base = '0;
    pos  = '0;
    hit  = 1'b0;
    // first range holding the symbol wins
    for (int i = 0; i < ascd_pkg::NumRanges; i++) begin
      if (3'(i) < a.cnt && !hit && symbol_or_index_i >= {7'd0, a.lo[i]}
          && symbol_or_index_i <= {7'd0, a.hi[i]}) begin
        pos = ascd_pkg::val_t'(base + symbol_or_index_i[13:0] - a.lo[i]);
        hit = 1'b1;
      end
      base = ascd_pkg::val_t'(base + ascd_pkg::range_len_f(a, i));
    end
    a0 = req_type_i ? symbol_or_index_i : {7'd0, pos};
    v  = {2'b00, a0} + {{7{shift_i[15]}}, shift_i};
    cell_d.valid = valid_i;
    cell_d.req   = req_type_i;
    cell_d.hit   = req_type_i | hit;
    cell_d.neg   = v[ascd_pkg::DvdW-1];
    cell_d.sch   = sch;
    cell_d.m     = a.len;
    cell_d.rem   = '0;
    cell_d.dvd   = v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// File: src/ascd_cell.sv
`default_nettype none
module ascd_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  ascd_pkg::cell_t      cell_i,
  output ascd_pkg::cell_t      cell_o
);

  logic [ascd_pkg::ValW:0] r2, diff;
  ascd_pkg::cell_t         cell_d, cell_q;

  // one restoring step: bring in the next dividend bit
  always_comb begin
    r2     = {cell_i.rem, cell_i.dvd[ascd_pkg::DvdW-1]};
    diff   = r2 - {1'b0, cell_i.m};
    cell_d = cell_i;
    cell_d.rem = diff[ascd_pkg::ValW] ? r2[ascd_pkg::ValW-1:0] : diff[ascd_pkg::ValW-1:0];
    cell_d.dvd = {cell_i.dvd[ascd_pkg::DvdW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// File: src/ascd_back.sv
`default_nettype none
module ascd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  ascd_pkg::cell_t    cell_i,
  output logic               valid_o,
  output logic [13:0]        result_value_o,
  output logic               found_o,
  output logic [13:0]        alphabet_length_o
);

  ascd_pkg::alpha_t a;
  logic [ascd_pkg::ValW:0] t;
  ascd_pkg::val_t   p, base, ln, value;
  logic             done;
  logic             valid_q, found_q;
  ascd_pkg::val_t   value_q, len_q;

  always_comb begin
    a = ascd_pkg::alpha_f(cell_i.sch);
    // undo the 2^23 offset of a negative sum
    t = {1'b0, cell_i.rem} - {1'b0, a.p23};
    if (t[ascd_pkg::ValW]) t = t + {1'b0, cell_i.m};
    p = cell_i.neg ? t[ascd_pkg::ValW-1:0] : cell_i.rem;
    base  = '0;
    done  = 1'b0;
    value = '0;
    if (cell_i.req) begin
      for (int i = 0; i < ascd_pkg::NumRanges; i++) begin
        ln = ascd_pkg::range_len_f(a, i);
        if (3'(i) < a.cnt && !done && p < ascd_pkg::val_t'(base + ln)) begin
          value = ascd_pkg::val_t'(a.lo[i] + p - base);
          done  = 1'b1;
        end
        base = ascd_pkg::val_t'(base + ln);
      end
    end else begin
      ln    = '0;
      value = cell_i.hit ? p : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value;
      found_q <= cell_i.hit;
      len_q   <= cell_i.m;
    end
  end

  assign valid_o           = valid_q;
  assign result_value_o    = value_q;
  assign found_o           = found_q;
  assign alphabet_length_o = len_q;

endmodule
`default_nettype wire

// File: src/alphabet_shift_encode_decode.sv
// shift encoder and decoder over fixed symbol alphabets
// input channel: in_valid_i / in_ready_o with req_type_i (0 encode, 1 decode),
//   scheme_type_i (alphabet id), symbol_or_index_i and signed shift_i
// output channel: out_valid_o / out_ready_i with result_value_o, found_o and
//   alphabet_length_o, one result item per input item, in order
// pipeline: front stage loaded at the accepting edge, then 23 cells of the remainder
//   chain and the output register that drives out_valid_o
// throughput: one item per cycle; the chain resolves one dividend bit per cell
// stall: the whole pipeline holds while a result waits and out_ready_i is low;
//   in_ready_o then drops, so nothing is lost or repeated
// reset: rst_ni clears all valid bits; the block is ready in the first cycle
`default_nettype none
module alphabet_shift_encode_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic [15:0]        scheme_type_i,
  input  wire logic [20:0]        symbol_or_index_i,
  input  wire logic signed [15:0] shift_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [13:0]             result_value_o,
  output logic                    found_o,
  output logic [13:0]             alphabet_length_o
);

  // pipeline advances whenever the output slot is free or being emptied
  logic en;
  ascd_pkg::cell_t chain [ascd_pkg::NumCells+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // position lookup and signed sum
  ascd_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i && en),
    .req_type_i, .scheme_type_i, .symbol_or_index_i, .shift_i,
    .cell_o(chain[0])
  );

  // modulo by alphabet length, one bit per cell
  for (genvar k = 0; k < ascd_pkg::NumCells; k++) begin : g_cell
    ascd_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .cell_i(chain[k]), .cell_o(chain[k+1])
    );
  end

  // sign fixup, map an index back to a code point on decode, output register
  ascd_back u_back (
    .clk_i, .rst_ni, .en_i(en), .cell_i(chain[ascd_pkg::NumCells]),
    .valid_o(out_valid_o), .result_value_o, .found_o, .alphabet_length_o
  );

endmodule
`default_nettype wire
